// ===== src/tlpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpr_pkg: shared types, constants and label helpers
// Field widths, request and register codes, and the digit-prefix match used
// by the next-hop unit and its cells.
// ----------------------------------------------------------------------------
package tlpr_pkg;

  // field widths
  localparam int unsigned LabelW   = 32;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PortW    = 6;
  localparam int unsigned VcW      = 4;
  localparam int unsigned NumVcW   = 5;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned NodeW    = 2;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;

  // label geometry
  localparam int MaxDigits = 8;
  localparam int DigitBits = 4;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxDigits);

  // defaults for the top level parameters
  localparam int MaxLinksDef   = 16;
  localparam int LocalNodesDef = 4;

  // request codes
  localparam logic [ReqW-1:0] REQ_WR_LINK  = 2'd0;
  localparam logic [ReqW-1:0] REQ_WR_LOCAL = 2'd1;
  localparam logic [ReqW-1:0] REQ_QUERY    = 2'd2;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_OWN_LABEL = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_OWN_LEN   = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_NUM_VCS   = 2'd2;

  // input word
  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [IdxW-1:0]   entry_index;
    logic              entry_present;
    logic [LabelW-1:0] link_tag;
    logic [LenW-1:0]   link_label_len;
    logic [PortW-1:0]  port_number;
    logic [NodeW-1:0]  node_index;
    logic [LabelW-1:0] dst_label;
    logic [LenW-1:0]   dst_label_len;
  } req_t;

  // result word
  typedef struct packed {
    logic [PortW-1:0] egress_port;
    logic             no_route;
    logic             is_local;
    logic [VcW-1:0]   highest_vc;
  } rsp_t;

  // query token that walks along the cell row
  typedef struct packed {
    logic              valid;
    logic [LabelW-1:0] dst_label;
    logic [LenW-1:0]   dst_len;
    logic              have_best;
    logic [LenW-1:0]   best_len;
    logic [PortW-1:0]  best_port;
    logic              have_up;
    logic [PortW-1:0]  up_port;
  } tok_t;

  // link entry write into one cell
  typedef struct packed {
    logic              en;
    logic              present;
    logic [LabelW-1:0] label;
    logic [LenW-1:0]   len;
    logic [PortW-1:0]  port;
  } wr_t;

  // lengths above the digit count saturate
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    return (len > MaxLen) ? MaxLen : len;
  endfunction

  // mask over the first len digits
  function automatic logic [LabelW-1:0] digit_mask(input logic [LenW-1:0] len);
    logic [LabelW-1:0] m;
    m = '0;
    for (int d = 0; d < MaxDigits; d++) begin
      for (int b = 0; b < DigitBits; b++) begin
        m[d*DigitBits+b] = (d < int'(len));
      end
    end
    return m;
  endfunction

  // first len digits of both labels agree
  function automatic logic label_match(input logic [LabelW-1:0] a,
                                       input logic [LabelW-1:0] b,
                                       input logic [LenW-1:0]   len);
    return ((a ^ b) & digit_mask(len)) == '0;
  endfunction

endpackage

// ===== src/tlpr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpr_cell: one link entry of the routing row
// Holds one link entry and updates the passing query token with the longest
// prefix match and the first up link, then hands it to the next cell.
// ----------------------------------------------------------------------------
module tlpr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tlpr_pkg::wr_t  wr_i,
  input  tlpr_pkg::tok_t tok_i,
  output tlpr_pkg::tok_t tok_o
);

  logic                          present_q;
  logic [tlpr_pkg::LabelW-1:0]   label_q;
  logic [tlpr_pkg::LenW-1:0]     len_q;
  logic [tlpr_pkg::PortW-1:0]    port_q;
  logic                          valid_q;
  tlpr_pkg::tok_t                tok_d;
  tlpr_pkg::tok_t                tok_q;
  logic [tlpr_pkg::LenW-1:0]     el;

  // entry present bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else if (wr_i.en) begin
      present_q <= wr_i.present;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      label_q <= wr_i.label;
      len_q   <= wr_i.len;
      port_q  <= wr_i.port;
    end
  end

  // match against the passing token
  always_comb begin
    el    = tlpr_pkg::clamp_len(len_q);
    tok_d = tok_i;
    if (present_q) begin
      if (el == '0) begin
        if (!tok_i.have_up) begin
          tok_d.have_up = 1'b1;
          tok_d.up_port = port_q;
        end
      end else if ((el <= tok_i.dst_len) && (el > tok_i.best_len) &&
                   tlpr_pkg::label_match(label_q, tok_i.dst_label, el)) begin
        tok_d.have_best = 1'b1;
        tok_d.best_len  = el;
        tok_d.best_port = port_q;
      end
    end
  end

  // token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== src/tree_label_prefix_router.sv =====
`timescale 1ns / 1ps
// A query passes the head register and the link cell registers into the result register.
// One query in flight at a time; busy_o stays high until its result strobe, while the
// token walks the row of link cells, and no new word is taken until then.
// Table writes may follow each other back to back.
// Reset clears all link present bits and loads own label 1, length 1, one vc.
// Results are strobed for one cycle only; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// tree_label_prefix_router: next-hop unit for a tree labeled network
// Local delivery on own label match, else longest link prefix match, else
// the up link, else no route; the link table lives in a row of cells that a query walks.
// ----------------------------------------------------------------------------
module tree_label_prefix_router #(
  parameter int NumLinks = tlpr_pkg::MaxLinksDef,
  parameter int NumLocal = tlpr_pkg::LocalNodesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  tlpr_pkg::req_t                  req_i,
  output logic                            valid_o,
  output tlpr_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tlpr_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [tlpr_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int LocalIdxW = (NumLocal > 1) ? $clog2(NumLocal) : 1;

  logic                          busy_q;
  logic                          accept;
  logic                          is_query;
  logic                          cfg_we;
  logic [tlpr_pkg::LabelW-1:0]   own_label_q;
  logic [tlpr_pkg::LenW-1:0]     own_len_q;
  logic [tlpr_pkg::NumVcW-1:0]   num_vcs_q;
  logic [tlpr_pkg::PortW-1:0]    local_port_q [NumLocal];
  logic [LocalIdxW-1:0]          lidx;
  logic                          node_ok;
  logic [tlpr_pkg::LenW-1:0]     dlen;
  logic                          loc_hit;
  logic                          loc_hit_q;
  logic                          loc_ok_q;
  logic [tlpr_pkg::PortW-1:0]    loc_port_q;
  logic                          head_valid_q;
  tlpr_pkg::tok_t                head_q;
  tlpr_pkg::tok_t                chain [NumLinks+1];
  tlpr_pkg::wr_t                 cell_wr [NumLinks];
  tlpr_pkg::tok_t                tail;
  tlpr_pkg::rsp_t                rsp_d;
  tlpr_pkg::rsp_t                rsp_q;
  logic                          valid_q;

  assign accept   = start_i && !busy_q;
  assign is_query = accept && (req_i.req_type == tlpr_pkg::REQ_QUERY);
  assign busy_o   = busy_q;
  assign valid_o  = valid_q;
  assign rsp_o    = rsp_q;

  // configuration registers, written only while no word is offered or in flight
  assign cfg_ready_o = !busy_q && !start_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_label_q <= tlpr_pkg::LabelW'(1);
      own_len_q   <= tlpr_pkg::LenW'(1);
      num_vcs_q   <= tlpr_pkg::NumVcW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr_i)
        tlpr_pkg::CFG_OWN_LABEL: own_label_q <= cfg_data_i[tlpr_pkg::LabelW-1:0];
        tlpr_pkg::CFG_OWN_LEN:   own_len_q   <= cfg_data_i[tlpr_pkg::LenW-1:0];
        tlpr_pkg::CFG_NUM_VCS:   num_vcs_q   <= cfg_data_i[tlpr_pkg::NumVcW-1:0];
        default: ;
      endcase
    end
  end

  // local node port table
  assign node_ok = int'(req_i.node_index) < NumLocal;
  assign lidx    = LocalIdxW'(req_i.node_index);

  always_ff @(posedge clk_i) begin
    if (accept && (req_i.req_type == tlpr_pkg::REQ_WR_LOCAL) && node_ok) begin
      local_port_q[lidx] <= req_i.port_number;
    end
  end

  // own label check, done as the query is taken
  assign dlen    = tlpr_pkg::clamp_len(req_i.dst_label_len);
  assign loc_hit = (tlpr_pkg::clamp_len(own_len_q) == dlen) &&
                   tlpr_pkg::label_match(own_label_q, req_i.dst_label, dlen);

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      loc_hit_q  <= loc_hit;
      loc_ok_q   <= node_ok;
      loc_port_q <= node_ok ? local_port_q[lidx] : '0;
    end
  end

  // query token at the head of the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= is_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      head_q.valid     <= 1'b1;
      head_q.dst_label <= req_i.dst_label;
      head_q.dst_len   <= dlen;
      head_q.have_best <= 1'b0;
      head_q.best_len  <= '0;
      head_q.best_port <= '0;
      head_q.have_up   <= 1'b0;
      head_q.up_port   <= '0;
    end
  end

  always_comb begin
    chain[0]       = head_q;
    chain[0].valid = head_valid_q;
  end

  // row of link cells
  for (genvar k = 0; k < NumLinks; k++) begin : g_cell
    always_comb begin
      cell_wr[k].en      = accept && (req_i.req_type == tlpr_pkg::REQ_WR_LINK) &&
                           (int'(req_i.entry_index) == k);
      cell_wr[k].present = req_i.entry_present;
      cell_wr[k].label   = req_i.link_tag;
      cell_wr[k].len     = req_i.link_label_len;
      cell_wr[k].port    = req_i.port_number;
    end

    tlpr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (cell_wr[k]),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  // final choice at the end of the row
  assign tail = chain[NumLinks];

  always_comb begin
    rsp_d = '0;
    if (loc_hit_q) begin
      rsp_d.is_local    = 1'b1;
      rsp_d.egress_port = loc_port_q;
      rsp_d.no_route    = !loc_ok_q;
    end else if (tail.have_best) begin
      rsp_d.egress_port = tail.best_port;
    end else if (tail.have_up) begin
      rsp_d.egress_port = tail.up_port;
    end else begin
      rsp_d.no_route = 1'b1;
    end
    if (num_vcs_q == '0) begin
      rsp_d.highest_vc = '0;
    end else if (num_vcs_q > tlpr_pkg::NumVcW'(16)) begin
      rsp_d.highest_vc = '1;
    end else begin
      rsp_d.highest_vc = tlpr_pkg::VcW'(num_vcs_q - tlpr_pkg::NumVcW'(1));
    end
  end

  // busy flag and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= tail.valid;
      if (is_query) begin
        busy_q <= 1'b1;
      end else if (tail.valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// ===== src/tlpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpr_checker: port-level checks for the next-hop unit
// Watches the command and result ports for strobe, busy and result rules.
// ----------------------------------------------------------------------------
module tlpr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input tlpr_pkg::req_t req_i,
  input logic           valid_o,
  input tlpr_pkg::rsp_t rsp_o
);

  // a result strobe lasts one cycle, one query at a time
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // busy ends exactly with the result strobe
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("busy dropped without a result");

  // every result belongs to a query in flight
  a_result_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without a query in flight");

  // table writes never produce a word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.req_type != tlpr_pkg::REQ_QUERY))
      |=> (!valid_o && !busy_o))
    else $error("non-query request produced a result or busy");

  // no route reports port zero
  a_no_route_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.no_route) |-> (rsp_o.egress_port == '0))
    else $error("no route with nonzero port");

endmodule

bind tree_label_prefix_router tlpr_checker u_tlpr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);
